// ===== hdl/mexp_pkg.sv =====
// Shared types and default widths for the modular exponentiation core.
`timescale 1ns / 1ps

package mexp_pkg;

   // default datapath widths
   localparam int unsigned MOD_WIDTH_DEF = 32;
   localparam int unsigned EXP_WIDTH_DEF = 64;

   // fixed field widths of the item ports
   localparam int unsigned BASE_WIDTH   = 32;
   localparam int unsigned EXPO_WIDTH   = 64;
   localparam int unsigned MODIN_WIDTH  = 32;
   localparam int unsigned RESULT_WIDTH = 32;

   typedef struct packed {
      logic [BASE_WIDTH-1:0]  base_value;
      logic [EXPO_WIDTH-1:0]  exponent;
      logic [MODIN_WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] result_value;
      logic                    bad_modulus;
   } rsp_type;

endpackage

// ===== hdl/mexp_modred.sv =====
// Bit-serial restoring reduction of a value modulo the modulus, one bit per cycle.
`timescale 1ns / 1ps

module mexp_modred #(
   parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_WIDTH-1:0] dividend,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] remainder
);

   localparam int unsigned CNT_WIDTH = $clog2(MOD_WIDTH + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0] rem_ff, rem_in;
   logic [MOD_WIDTH-1:0] div_ff, div_in;

   logic [MOD_WIDTH:0]   trial;
   logic [MOD_WIDTH:0]   trial_sub;
   logic                 last_step;

   // shift the next dividend bit into the partial remainder and subtract if it fits
   assign trial     = {rem_ff, div_ff[MOD_WIDTH-1]};
   assign trial_sub = trial - {1'b0, modulus};
   assign last_step = (cnt_ff == CNT_WIDTH'(MOD_WIDTH - 1));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = dividend;
      end else if (run_ff) begin
         if (trial >= {1'b0, modulus}) begin
            rem_in = trial_sub[MOD_WIDTH-1:0];
         end else begin
            rem_in = trial[MOD_WIDTH-1:0];
         end
         div_in = div_ff << 1;
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/mexp_modmul.sv =====
// Bit-serial modular multiplier: double and conditional add, one half-step per cycle.
`timescale 1ns / 1ps

module mexp_modmul #(
   parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_WIDTH-1:0] op_a,
   input  logic [MOD_WIDTH-1:0] op_b,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] product
);

   localparam int unsigned CNT_WIDTH = $clog2(MOD_WIDTH + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 phase_ff, phase_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] a_ff, a_in;
   logic [MOD_WIDTH-1:0] b_ff, b_in;

   logic [MOD_WIDTH-1:0] a_red;
   logic [MOD_WIDTH-1:0] addend;
   logic                 add_en;
   logic [MOD_WIDTH:0]   sum;
   logic [MOD_WIDTH:0]   sum_sub;
   logic                 last_step;

   // fold operand a below the modulus (it is never more than twice it)
   assign a_red = (op_a >= modulus) ? (op_a - modulus) : op_a;

   // phase 0 doubles the accumulator, phase 1 adds a when the next b bit is set
   assign addend    = phase_ff ? a_ff : acc_ff;
   assign add_en    = phase_ff ? b_ff[MOD_WIDTH-1] : 1'b1;
   assign sum       = {1'b0, acc_ff} + {1'b0, addend};
   assign sum_sub   = sum - {1'b0, modulus};
   assign last_step = phase_ff && (cnt_ff == CNT_WIDTH'(MOD_WIDTH - 1));

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      if (start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         acc_in   = '0;
         a_in     = a_red;
         b_in     = op_b;
      end else if (run_ff) begin
         if (add_en) begin
            if (sum >= {1'b0, modulus}) begin
               acc_in = sum_sub[MOD_WIDTH-1:0];
            end else begin
               acc_in = sum[MOD_WIDTH-1:0];
            end
         end
         phase_in = ~phase_ff;
         if (phase_ff) begin
            b_in   = b_ff << 1;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
         end
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hdl/modular_exponentiation_core.sv =====
// Top level: right-to-left square-and-multiply sequencer around bit-serial units.
// A zero modulus answers in the cycle after accept.
// A new item is taken only while idle (busy low); each exponent bit costs one pass of the two
//   bit-serial multipliers (square and multiply run side by side).
// Reset clears the sequencer and the strobe; the receiver cannot stall, so each
//   result is shown for one cycle only.
`timescale 1ns / 1ps

module modular_exponentiation_core #(
   parameter int unsigned MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
   parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mexp_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mexp_pkg::rsp_type rsp_data
);

   localparam int unsigned BCNT_WIDTH = $clog2(EXP_WIDTH + 1);
   localparam int unsigned RES_WIDTH  = mexp_pkg::RESULT_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_LAUNCH = 4'b0100,
      ST_WAIT   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [MOD_WIDTH-1:0]  m_ff, m_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]  res_ff, res_in;
   logic [MOD_WIDTH-1:0]  pw_ff, pw_in;
   logic [BCNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   mexp_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  accept;
   logic [MOD_WIDTH-1:0]  req_base;
   logic [MOD_WIDTH-1:0]  req_mod;
   logic [EXP_WIDTH-1:0]  req_exp;
   logic                  red_start;
   logic                  red_done;
   logic [MOD_WIDTH-1:0]  red_rem;
   logic                  mul_start;
   logic                  sq_done;
   logic [MOD_WIDTH-1:0]  sq_prod;
   logic                  ml_done;
   logic [MOD_WIDTH-1:0]  ml_prod;
   logic [MOD_WIDTH-1:0]  res_next;

   // take the low bits of each field that the datapath uses
   assign req_base  = MOD_WIDTH'(req_data.base_value);
   assign req_mod   = MOD_WIDTH'(req_data.modulus);
   assign req_exp   = EXP_WIDTH'(req_data.exponent);

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign red_start = accept && (req_mod != '0);
   assign mul_start = (state_ff == ST_LAUNCH);
   assign res_next  = exp_ff[0] ? ml_prod : res_ff;

   // reduce the base modulo the modulus
   mexp_modred #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (req_base),
      .modulus   (m_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   // square the running power
   mexp_modmul #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_square (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (pw_ff),
      .op_b    (pw_ff),
      .modulus (m_ff),
      .done    (sq_done),
      .product (sq_prod)
   );

   // multiply the result by the running power; kept only for a set exponent bit
   mexp_modmul #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_multiply (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (res_ff),
      .op_b    (pw_ff),
      .modulus (m_ff),
      .done    (ml_done),
      .product (ml_prod)
   );

   // sequence: reduce, then one square-and-multiply pass per exponent bit; a zero modulus is flagged straight from idle
   always_comb begin
      state_in      = state_ff;
      m_in          = m_ff;
      exp_in        = exp_ff;
      res_in        = res_ff;
      pw_in         = pw_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               m_in   = req_mod;
               exp_in = req_exp;
               if (req_mod == '0) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.result_value = '0;
                  rsp_in.bad_modulus  = 1'b1;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               pw_in      = red_rem;
               res_in     = MOD_WIDTH'(1);
               bit_cnt_in = '0;
               state_in   = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sq_done) begin
               pw_in  = sq_prod;
               res_in = res_next;
               exp_in = exp_ff >> 1;
               if (bit_cnt_ff == BCNT_WIDTH'(EXP_WIDTH - 1)) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.result_value = RES_WIDTH'(res_next);
                  rsp_in.bad_modulus  = 1'b0;
                  state_in            = ST_IDLE;
               end else begin
                  bit_cnt_in = bit_cnt_ff + BCNT_WIDTH'(1);
                  state_in   = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      m_ff       <= m_in;
      exp_ff     <= exp_in;
      res_ff     <= res_in;
      pw_ff      <= pw_in;
      bit_cnt_ff <= bit_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a zero modulus answers at once with the error flag
   a_bad_modulus_reply: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mod == '0)) |=> (rsp_strobe && rsp_data.bad_modulus))
      else $error("zero modulus did not give an immediate flagged item");

   // a flagged item always carries a zero result
   a_bad_modulus_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.bad_modulus) |-> (rsp_data.result_value == '0))
      else $error("flagged item with nonzero result");

   // the two multipliers run in lockstep
   a_units_lockstep: assert property (@(posedge clock) disable iff (reset)
      sq_done == ml_done)
      else $error("square and multiply units out of step");

   // operands stay reduced at every launch
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH) |-> ((pw_ff < m_ff) && ((res_ff < m_ff) || (res_ff == MOD_WIDTH'(1)))))
      else $error("operand not reduced below the modulus");

endmodule
